@@ rtl/isnr_pkg.sv @@
`default_nettype none
package isnr_pkg;

   localparam int DEFAULT_SAMPLE_BITS = 16;
   localparam int DEFAULT_COUNT_BITS  = 24;

   localparam int LOG_FRAC    = 24;
   localparam int MANT_BITS   = 32;
   localparam int SCALE_BITS  = 26;
   localparam int ROUND_SHIFT = 40;
   localparam logic [SCALE_BITS-1:0] SNR_SCALE = 26'd50504453;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NOISE_ZERO  = 2'd1;
   localparam logic [1:0] STATUS_SIGNAL_ZERO = 2'd2;
   localparam logic [1:0] STATUS_BOTH_ZERO   = 2'd3;

   localparam logic [15:0] SNR_MAX  = 16'h7FFF;
   localparam logic [15:0] SNR_MIN  = 16'h8000;
   localparam logic [15:0] SNR_ZERO = 16'h0000;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_MUL_LOAD,
      ST_MUL_RUN,
      ST_MUL_DONE,
      ST_CHECK,
      ST_LOG_LOAD,
      ST_NORM,
      ST_FRAC_INIT,
      ST_FRAC,
      ST_LOG_STORE,
      ST_SCALE,
      ST_ROUND,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_REF_SQ,
      MUL_REF_N,
      MUL_DIFF_SQ,
      MUL_DIFF_N
   } mul_op_type;

   typedef struct packed {
      logic       take;
      logic       mul_load;
      logic       mul_step;
      logic       mul_done;
      mul_op_type mul_op;
      logic       log_load;
      logic       norm_step;
      logic       frac_init;
      logic       frac_step;
      logic       log_store;
      logic       log_sel;
      logic       scale;
      logic       round;
      logic       result_load;
   } cmd_type;

   typedef struct packed {
      logic norm_done;
      logic a_zero;
      logic b_zero;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/isnr_req_if.sv @@
`default_nettype none
interface isnr_req_if import isnr_pkg::*; #(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] reference_sample;
   logic signed [SAMPLE_BITS-1:0] test_sample;
   logic                          last_sample;

   modport source (output valid, reference_sample, test_sample, last_sample, input ready);
   modport sink   (input valid, reference_sample, test_sample, last_sample, output ready);
endinterface
`default_nettype wire

@@ rtl/isnr_rsp_if.sv @@
`default_nettype none
interface isnr_rsp_if import isnr_pkg::*; #(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
);
   logic                  valid;
   logic                  ready;
   logic signed [15:0]    snr_db;
   logic [1:0]            status;
   logic [COUNT_BITS-1:0] pixel_count;

   modport source (output valid, snr_db, status, pixel_count, input ready);
   modport sink   (input valid, snr_db, status, pixel_count, output ready);
endinterface
`default_nettype wire

@@ rtl/isnr_ctrl.sv @@
`default_nettype none
module isnr_ctrl import isnr_pkg::*; #(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
   parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_last,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   localparam int MW       = SAMPLE_BITS + 1 + COUNT_BITS;
   localparam int STEP_MAX = (MW > LOG_FRAC) ? MW : LOG_FRAC;
   localparam int SW       = $clog2(STEP_MAX);

   state_type      state_ff, state_in;
   mul_op_type     op_ff, op_in;
   logic [SW-1:0]  step_ff, step_in;
   logic           sel_ff, sel_in;
   logic           take;

   assign req_ready = (state_ff == ST_ACCUM);
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         op_ff    <= MUL_REF_SQ;
         step_ff  <= '0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         step_ff  <= step_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      step_in  = step_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (take && req_last) begin
               state_in = ST_MUL_LOAD;
               op_in    = MUL_REF_SQ;
            end
         end
         ST_MUL_LOAD: begin
            step_in  = '0;
            state_in = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(MW - 1)) state_in = ST_MUL_DONE;
         end
         ST_MUL_DONE: begin
            if (op_ff == MUL_DIFF_N) begin
               state_in = ST_CHECK;
            end else begin
               op_in    = mul_op_type'(op_ff + 2'd1);
               state_in = ST_MUL_LOAD;
            end
         end
         ST_CHECK: begin
            sel_in = 1'b0;
            if (stat.a_zero || stat.b_zero) state_in = ST_OUTPUT;
            else state_in = ST_LOG_LOAD;
         end
         ST_LOG_LOAD: state_in = ST_NORM;
         ST_NORM: begin
            if (stat.norm_done) state_in = ST_FRAC_INIT;
         end
         ST_FRAC_INIT: begin
            step_in  = '0;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(LOG_FRAC - 1)) state_in = ST_LOG_STORE;
         end
         ST_LOG_STORE: begin
            if (sel_ff) begin
               state_in = ST_SCALE;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_LOG_LOAD;
            end
         end
         ST_SCALE: state_in = ST_ROUND;
         ST_ROUND: state_in = ST_OUTPUT;
         ST_OUTPUT: begin
            if (stat.out_free) state_in = ST_ACCUM;
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.mul_op      = op_ff;
      cmd.log_sel     = sel_ff;
      cmd.take        = take;
      cmd.mul_load    = (state_ff == ST_MUL_LOAD);
      cmd.mul_step    = (state_ff == ST_MUL_RUN);
      cmd.mul_done    = (state_ff == ST_MUL_DONE);
      cmd.log_load    = (state_ff == ST_LOG_LOAD);
      cmd.norm_step   = (state_ff == ST_NORM) && !stat.norm_done;
      cmd.frac_init   = (state_ff == ST_FRAC_INIT);
      cmd.frac_step   = (state_ff == ST_FRAC);
      cmd.log_store   = (state_ff == ST_LOG_STORE);
      cmd.scale       = (state_ff == ST_SCALE);
      cmd.round       = (state_ff == ST_ROUND);
      cmd.result_load = (state_ff == ST_OUTPUT) && stat.out_free;
   end

endmodule
`default_nettype wire

@@ rtl/isnr_datapath.sv @@
`default_nettype none
module isnr_datapath import isnr_pkg::*; #(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
   parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output stat_type                    stat,
   input  wire logic [SAMPLE_BITS-1:0] ref_sample,
   input  wire logic [SAMPLE_BITS-1:0] test_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [15:0]                 rsp_snr_db,
   output logic [1:0]                  rsp_status,
   output logic [COUNT_BITS-1:0]       rsp_pixel_count
);
   localparam int SB  = SAMPLE_BITS;
   localparam int CB  = COUNT_BITS;
   localparam int RSW = SB + CB;
   localparam int DSW = SB + 1 + CB;
   localparam int RQW = 2 * SB + CB;
   localparam int DQW = 2 * SB + 2 + CB;
   localparam int W   = 2 * DSW;
   localparam int MW  = DSW;
   localparam int EW  = $clog2(W);
   localparam int LQ  = EW + LOG_FRAC;
   localparam int LW  = LQ + 1;
   localparam int PW  = LW + SCALE_BITS;
   localparam int QW  = PW - ROUND_SHIFT;

   // accumulators
   logic [CB-1:0]  count_ff, count_in;
   logic [RSW-1:0] ref_sum_ff, ref_sum_in;
   logic [RQW-1:0] ref_sq_ff, ref_sq_in;
   logic [DSW-1:0] diff_sum_ff, diff_sum_in;
   logic [DQW-1:0] diff_sq_ff, diff_sq_in;

   logic [SB:0]     diff;
   logic [SB-1:0]   ref_mag;
   logic [SB:0]     diff_mag;
   logic [2*SB-1:0] ref_pow;
   logic [2*SB+1:0] diff_pow;
   logic            count_full;

   assign diff     = {test_sample[SB-1], test_sample} - {ref_sample[SB-1], ref_sample};
   assign ref_mag  = ref_sample[SB-1] ? (~ref_sample + 1'b1) : ref_sample;
   assign diff_mag = diff[SB] ? (~diff + 1'b1) : diff;
   assign ref_pow  = (2*SB)'(ref_mag) * (2*SB)'(ref_mag);
   assign diff_pow = (2*SB+2)'(diff_mag) * (2*SB+2)'(diff_mag);
   assign count_full = &count_ff;

   always_comb begin
      priority if (cmd.result_load) begin
         count_in    = '0;
         ref_sum_in  = '0;
         ref_sq_in   = '0;
         diff_sum_in = '0;
         diff_sq_in  = '0;
      end else if (cmd.take && !count_full) begin
         count_in    = count_ff + 1'b1;
         ref_sum_in  = ref_sum_ff + {{(RSW-SB){ref_sample[SB-1]}}, ref_sample};
         ref_sq_in   = ref_sq_ff + RQW'(ref_pow);
         diff_sum_in = diff_sum_ff + {{(DSW-SB-1){diff[SB]}}, diff};
         diff_sq_in  = diff_sq_ff + DQW'(diff_pow);
      end else begin
         count_in    = count_ff;
         ref_sum_in  = ref_sum_ff;
         ref_sq_in   = ref_sq_ff;
         diff_sum_in = diff_sum_ff;
         diff_sq_in  = diff_sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         ref_sum_ff  <= '0;
         ref_sq_ff   <= '0;
         diff_sum_ff <= '0;
         diff_sq_ff  <= '0;
      end else begin
         count_ff    <= count_in;
         ref_sum_ff  <= ref_sum_in;
         ref_sq_ff   <= ref_sq_in;
         diff_sum_ff <= diff_sum_in;
         diff_sq_ff  <= diff_sq_in;
      end
   end

   // shift-add multiplier and spread
   logic [RSW-1:0] ref_sum_mag;
   logic [DSW-1:0] diff_sum_mag;
   logic [W-1:0]   mcand_ff, mcand_in;
   logic [MW-1:0]  mplier_ff, mplier_in;
   logic [W-1:0]   prod_ff, prod_in;
   logic [W-1:0]   sq_ff, sq_in;
   logic [W-1:0]   a_ff, a_in;
   logic [W-1:0]   b_ff, b_in;
   logic [W-1:0]   spread;

   assign ref_sum_mag  = ref_sum_ff[RSW-1] ? (~ref_sum_ff + 1'b1) : ref_sum_ff;
   assign diff_sum_mag = diff_sum_ff[DSW-1] ? (~diff_sum_ff + 1'b1) : diff_sum_ff;
   assign spread       = (prod_ff < sq_ff) ? '0 : (prod_ff - sq_ff);

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      sq_in     = sq_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      if (cmd.mul_load) begin
         prod_in = '0;
         unique case (cmd.mul_op)
            MUL_REF_SQ: begin
               mcand_in  = W'(ref_sum_mag);
               mplier_in = MW'(ref_sum_mag);
            end
            MUL_REF_N: begin
               mcand_in  = W'(ref_sq_ff);
               mplier_in = MW'(count_ff);
            end
            MUL_DIFF_SQ: begin
               mcand_in  = W'(diff_sum_mag);
               mplier_in = MW'(diff_sum_mag);
            end
            MUL_DIFF_N: begin
               mcand_in  = W'(diff_sq_ff);
               mplier_in = MW'(count_ff);
            end
            default: begin
               mcand_in  = '0;
               mplier_in = '0;
            end
         endcase
      end
      if (cmd.mul_step) begin
         if (mplier_ff[0]) prod_in = prod_ff + mcand_ff;
         mcand_in  = {mcand_ff[W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MW-1:1]};
      end
      if (cmd.mul_done) begin
         unique case (cmd.mul_op)
            MUL_REF_SQ, MUL_DIFF_SQ: sq_in = prod_ff;
            MUL_REF_N:               a_in  = spread;
            MUL_DIFF_N:              b_in  = spread;
            default:                 sq_in = prod_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      sq_ff     <= sq_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
   end

   // log2 by normalization and repeated squaring
   logic [W-1:0]           norm_ff, norm_in;
   logic [EW-1:0]          exp_ff, exp_in;
   logic [MANT_BITS-1:0]   x_ff, x_in;
   logic [LOG_FRAC-1:0]    frac_ff, frac_in;
   logic [LQ-1:0]          la_ff, la_in;
   logic [LQ-1:0]          lb_ff, lb_in;
   logic [2*MANT_BITS-1:0] x_pow;
   logic [MANT_BITS:0]     x_next;

   assign x_pow  = (2*MANT_BITS)'(x_ff) * (2*MANT_BITS)'(x_ff);
   assign x_next = x_pow[2*MANT_BITS-1:MANT_BITS-1];

   always_comb begin
      norm_in = norm_ff;
      exp_in  = exp_ff;
      x_in    = x_ff;
      frac_in = frac_ff;
      la_in   = la_ff;
      lb_in   = lb_ff;
      if (cmd.log_load) begin
         norm_in = cmd.log_sel ? b_ff : a_ff;
         exp_in  = EW'(W - 1);
      end
      if (cmd.norm_step) begin
         norm_in = {norm_ff[W-2:0], 1'b0};
         exp_in  = exp_ff - 1'b1;
      end
      if (cmd.frac_init) begin
         x_in    = norm_ff[W-1 -: MANT_BITS];
         frac_in = '0;
      end
      if (cmd.frac_step) begin
         x_in    = x_next[MANT_BITS] ? x_next[MANT_BITS:1] : x_next[MANT_BITS-1:0];
         frac_in = {frac_ff[LOG_FRAC-2:0], x_next[MANT_BITS]};
      end
      if (cmd.log_store) begin
         if (cmd.log_sel) lb_in = {exp_ff, frac_ff};
         else la_in = {exp_ff, frac_ff};
      end
   end

   always_ff @(posedge clock) begin
      norm_ff <= norm_in;
      exp_ff  <= exp_in;
      x_ff    <= x_in;
      frac_ff <= frac_in;
      la_ff   <= la_in;
      lb_ff   <= lb_in;
   end

   // dB scaling and rounding
   logic [LW-1:0] dl;
   logic [LW-1:0] dl_mag;
   logic [PW-1:0] scaled_ff;
   logic          neg_ff;
   logic [PW-1:0] rounded;
   logic [QW-1:0] q;
   logic [15:0]   snr_calc_ff, snr_calc_in;

   assign dl      = {1'b0, la_ff} - {1'b0, lb_ff};
   assign dl_mag  = dl[LW-1] ? (~dl + 1'b1) : dl;
   assign rounded = scaled_ff + (PW'(1) << (ROUND_SHIFT - 1));
   assign q       = rounded[PW-1:ROUND_SHIFT];

   always_comb begin
      snr_calc_in = snr_calc_ff;
      if (cmd.round) begin
         if (neg_ff) snr_calc_in = (q >= QW'(32768)) ? SNR_MIN : (~q[15:0] + 1'b1);
         else snr_calc_in = (q > QW'(32767)) ? SNR_MAX : q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         scaled_ff <= PW'(dl_mag) * PW'(SNR_SCALE);
         neg_ff    <= dl[LW-1];
      end
      snr_calc_ff <= snr_calc_in;
   end

   // result register
   logic        a_zero, b_zero;
   logic [1:0]  status_now;
   logic [15:0] snr_now;
   logic        valid_ff;
   logic [15:0] snr_ff;
   logic [1:0]  status_ff;
   logic [CB-1:0] pcount_ff;

   assign a_zero     = (a_ff == '0);
   assign b_zero     = (b_ff == '0);
   assign status_now = {a_zero, b_zero};

   always_comb begin
      unique case (status_now)
         STATUS_OK:          snr_now = snr_calc_ff;
         STATUS_NOISE_ZERO:  snr_now = SNR_MAX;
         STATUS_SIGNAL_ZERO: snr_now = SNR_MIN;
         STATUS_BOTH_ZERO:   snr_now = SNR_ZERO;
         default:            snr_now = SNR_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.result_load) begin
         snr_ff    <= snr_now;
         status_ff <= status_now;
         pcount_ff <= count_ff;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_snr_db      = snr_ff;
   assign rsp_status      = status_ff;
   assign rsp_pixel_count = pcount_ff;

   assign stat.norm_done = norm_ff[W-1];
   assign stat.a_zero    = a_zero;
   assign stat.b_zero    = b_zero;
   assign stat.out_free  = !valid_ff || rsp_ready;

endmodule
`default_nettype wire

@@ rtl/image_snr_db_accumulator_unit.sv @@
// Pixel pairs are taken one per cycle while accumulating; each pair is added to the registered sums.
// After the last pair the ratio is formed by a shared shift-add multiplier, four products of
// S+C+1 steps each, then two log2 runs (up to 2(S+C+1) normalize steps plus 24 squaring
// steps each), scaling and rounding, skipped when a spread is zero; then the result waits.
// Requests are refused from the last pair until its result enters the output register.
// Synchronous reset clears the sums, the count, the controller and the output valid.
`default_nettype none
module image_snr_db_accumulator_unit import isnr_pkg::*; #(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
   parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
) (
   input wire logic    clock,
   input wire logic    reset,
   isnr_req_if.sink    req_stream,
   isnr_rsp_if.source  rsp_stream
);
   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_stream.ready = req_ready;

   isnr_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_stream.valid),
      .req_last  (req_stream.last_sample),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   isnr_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .ref_sample      (req_stream.reference_sample),
      .test_sample     (req_stream.test_sample),
      .rsp_valid       (rsp_stream.valid),
      .rsp_ready       (rsp_stream.ready),
      .rsp_snr_db      (rsp_stream.snr_db),
      .rsp_status      (rsp_stream.status),
      .rsp_pixel_count (rsp_stream.pixel_count)
   );

endmodule
`default_nettype wire

@@ rtl/isnr_checker.sv @@
`default_nettype none
module isnr_checker import isnr_pkg::*; #(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  req_last,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [15:0]           snr_db,
   input wire logic [1:0]            status,
   input wire logic [COUNT_BITS-1:0] pixel_count
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(snr_db) && $stable(status)
                                  && $stable(pixel_count))
      else $error("rsp payload changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status != STATUS_NOISE_ZERO || snr_db == SNR_MAX)
                 && (status != STATUS_SIGNAL_ZERO || snr_db == SNR_MIN)
                 && (status != STATUS_BOTH_ZERO || snr_db == SNR_ZERO))
      else $error("snr_db does not match status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pixel_count != '0)
      else $error("result with zero pixel count");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("request taken right after last pair");

endmodule

bind image_snr_db_accumulator_unit isnr_checker #(
   .COUNT_BITS (COUNT_BITS)
) u_isnr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_stream.valid),
   .req_ready   (req_stream.ready),
   .req_last    (req_stream.last_sample),
   .rsp_valid   (rsp_stream.valid),
   .rsp_ready   (rsp_stream.ready),
   .snr_db      (rsp_stream.snr_db),
   .status      (rsp_stream.status),
   .pixel_count (rsp_stream.pixel_count)
);
`default_nettype wire
